[design/at_response_matcher_top_macros.svh]
// ----------------------------------------------------------------------------
// at_response_matcher_top_macros
// assertion macros for the checks in the matcher top
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_MATCHER_TOP_MACROS_SVH
`define AT_RESPONSE_MATCHER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ARM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("at_response_matcher same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ARM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("at_response_matcher next-cycle check failed");

`endif

[design/arm_pkg.sv]
// ----------------------------------------------------------------------------
// arm_pkg
// types, codes and constants of the modem reply matcher
// ----------------------------------------------------------------------------
package arm_pkg;

  // fixed limits of the reply window
  localparam int SKIP_BYTES = 32;
  localparam int MAX_BYTES  = 2000;
  localparam int ACK_MAX    = 8;

  // field widths
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 64;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_WAIT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACK     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ERR     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOWIN   = 3'd5;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ACK_TEXT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ACK_LEN  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT  = 2'd2;

  // configuration reset values ("OK", two bytes, 500 ticks)
  localparam logic [63:0] ACK_TEXT_RST = 64'd19279;
  localparam logic [3:0]  ACK_LEN_RST  = 4'd2;
  localparam logic [15:0] TIMEOUT_RST  = 16'd500;

  // configuration seen by the matcher
  typedef struct packed {
    logic [63:0] ack_text;
    logic [3:0]  ack_len;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

[design/arm_if.sv]
// ----------------------------------------------------------------------------
// arm_if
// valid/ready channels of the reply matcher: input, result, configuration
// ----------------------------------------------------------------------------
interface arm_in_if;
  import arm_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface arm_out_if;
  import arm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

interface arm_cfg_if;
  import arm_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/arm_cfg.sv]
// ----------------------------------------------------------------------------
// arm_cfg
// configuration register file of the reply matcher
// ----------------------------------------------------------------------------
module arm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [arm_pkg::CIDX_W-1:0]   wr_index,
  input  logic [arm_pkg::CDATA_W-1:0]  wr_data,
  output arm_pkg::cfg_t                cfg
);
  import arm_pkg::*;

  logic [63:0] ack_text_r;
  logic [3:0]  ack_len_r;
  logic [15:0] timeout_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_text_r <= ACK_TEXT_RST;
      ack_len_r  <= ACK_LEN_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACK_TEXT: ack_text_r <= wr_data;
        REG_ACK_LEN:  ack_len_r  <= wr_data[3:0];
        REG_TIMEOUT:  timeout_r  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.ack_text      = ack_text_r;
  assign cfg.ack_len       = ack_len_r;
  assign cfg.timeout_ticks = timeout_r;

endmodule

[design/arm_core.sv]
// ----------------------------------------------------------------------------
// arm_core
// reply window state and per-item matcher step
// ----------------------------------------------------------------------------
module arm_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [arm_pkg::KIND_W-1:0]    kind,
  input  logic [arm_pkg::BYTE_W-1:0]    rx_byte,
  input  arm_pkg::cfg_t                 cfg,
  output logic [arm_pkg::STATUS_W-1:0]  status
);
  import arm_pkg::*;

  localparam logic [39:0]  ERR_TEXT  = 40'h524F525245; // "ERROR", first char low
  localparam logic [5:0]   SKIP_INIT = 6'(SKIP_BYTES);
  localparam logic [10:0]  MAX_CNT   = 11'(MAX_BYTES);
  localparam logic [3:0]   ACK_LIM   = 4'(ACK_MAX);

  logic        first_r, first_nxt;
  logic        open_r, open_nxt;
  logic [5:0]  skip_r, skip_nxt;
  logic [3:0]  ackp_r, ackp_nxt;
  logic [2:0]  errp_r, errp_nxt;
  logic [10:0] seen_r, seen_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic [3:0]  eff_len;
  logic [2:0]  ack_p;
  logic [2:0]  err_p;
  logic [7:0]  ack_want;
  logic [7:0]  err_want;
  logic [3:0]  ack_inc;
  logic [2:0]  err_inc;
  logic [10:0] seen_inc;
  logic [15:0] idle_inc;

  // effective ack length, zero acts as one, clipped to the maximum
  always_comb begin
    eff_len = cfg.ack_len;
    if (eff_len == 4'd0) eff_len = 4'd1;
    if (eff_len > ACK_LIM) eff_len = ACK_LIM;
  end

  // expected characters of both matchers
  assign ack_p    = ackp_r[2:0];
  assign err_p    = (errp_r > 3'd4) ? 3'd0 : errp_r;
  assign ack_want = cfg.ack_text[{ack_p, 3'b000} +: 8];
  assign err_want = ERR_TEXT[{err_p, 3'b000} +: 8];
  assign ack_inc  = {1'b0, ack_p} + 4'd1;
  assign err_inc  = err_p + 3'd1;
  assign seen_inc = seen_r + 11'd1;
  assign idle_inc = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;

  // one step of the window for the item at the input
  always_comb begin
    first_nxt = first_r;
    open_nxt  = open_r;
    skip_nxt  = skip_r;
    ackp_nxt  = ackp_r;
    errp_nxt  = errp_r;
    seen_nxt  = seen_r;
    idle_nxt  = idle_r;
    status    = ST_WAIT;
    if (kind == KIND_START) begin
      open_nxt  = 1'b1;
      skip_nxt  = first_r ? SKIP_INIT : 6'd0;
      first_nxt = 1'b0;
      ackp_nxt  = 4'd0;
      errp_nxt  = 3'd0;
      seen_nxt  = 11'd0;
      idle_nxt  = 16'd0;
    end else if (!open_r) begin
      status = ST_NOWIN;
    end else if (kind == KIND_BYTE) begin
      idle_nxt = 16'd0;
      if (skip_r != 6'd0) begin
        skip_nxt = skip_r - 6'd1;
      end else begin
        seen_nxt = seen_inc;
        // ack matcher first, it wins a tie
        if (rx_byte == ack_want) begin
          ackp_nxt = ack_inc;
        end else begin
          ackp_nxt = 4'd0;
        end
        if (rx_byte == ack_want && ack_inc >= eff_len) begin
          open_nxt = 1'b0;
          status   = ST_ACK;
        end else begin
          if (rx_byte == err_want) begin
            errp_nxt = err_inc;
          end else begin
            errp_nxt = 3'd0;
          end
          if (rx_byte == err_want && err_inc >= 3'd5) begin
            open_nxt = 1'b0;
            status   = ST_ERR;
          end else if (seen_inc >= MAX_CNT) begin
            open_nxt = 1'b0;
            status   = ST_LIMIT;
          end
        end
      end
    end else if (kind == KIND_TICK) begin
      idle_nxt = idle_inc;
      if (idle_inc >= cfg.timeout_ticks) begin
        open_nxt = 1'b0;
        status   = ST_TIMEOUT;
      end
    end
  end

  // window state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      open_r  <= 1'b0;
      skip_r  <= 6'd0;
      ackp_r  <= 4'd0;
      errp_r  <= 3'd0;
      seen_r  <= 11'd0;
      idle_r  <= 16'd0;
    end else if (accept) begin
      first_r <= first_nxt;
      open_r  <= open_nxt;
      skip_r  <= skip_nxt;
      ackp_r  <= ackp_nxt;
      errp_r  <= errp_nxt;
      seen_r  <= seen_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

[design/arm_out_stage.sv]
// ----------------------------------------------------------------------------
// arm_out_stage
// result register with backpressure toward the input side
// ----------------------------------------------------------------------------
module arm_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arm_pkg::STATUS_W-1:0]  in_status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [arm_pkg::STATUS_W-1:0]  out_status
);
  import arm_pkg::*;

  logic                valid_r;
  logic [STATUS_W-1:0] status_r;

  // free when empty or being drained this cycle
  assign in_ready = !valid_r || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      status_r <= in_status;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule

[design/at_response_matcher_top.sv]
// ----------------------------------------------------------------------------
// at_response_matcher_top
// modem reply matcher: ack text, ERROR text, timeout and byte limit
// ----------------------------------------------------------------------------
// timing: the result of an accepted transaction is registered and shown on out_ch in the next cycle
// throughput: one transaction per cycle while out_ch is not stalled, set by the single result register
// reset (rst_n low, synchronous): window closed, first-window skip armed,
// result channel empty, registers back to "OK", length 2, 500 ticks
`include "at_response_matcher_top_macros.svh"

module at_response_matcher_top (
  input  logic      clk,
  input  logic      rst_n,
  arm_in_if.sink    in_ch,
  arm_out_if.source out_ch,
  arm_cfg_if.sink   cfg_ch
);
  import arm_pkg::*;

  cfg_t                cfg;
  logic                in_accept;
  logic                stage_ready;
  logic [STATUS_W-1:0] step_status;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  arm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // input handshake
  assign in_ch.ready = stage_ready;
  assign in_accept   = in_ch.valid && stage_ready;

  arm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .kind    (in_ch.kind),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg),
    .status  (step_status)
  );

  arm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (stage_ready),
    .in_status  (step_status),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status)
  );

  // checks
  `ARM_ASSERT_IMP(a_stall_blocks_input, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `ARM_ASSERT_NEXT(a_accept_gives_result, in_ch.valid && in_ch.ready, out_ch.valid)
  `ARM_ASSERT_NEXT(a_timeout_only_on_tick, in_accept && in_ch.kind != KIND_TICK, out_ch.status != ST_TIMEOUT)

endmodule
